FILE: design/merge_sorter_unit_macros.svh
// ----------------------------------------------------------------------------
// merge_sorter_unit_macros
// assertion helpers shared by the merge sorter checker
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_UNIT_MACROS_SVH
`define MERGE_SORTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// shared types of the merge sorter cell row
// ----------------------------------------------------------------------------
`default_nettype none

package msort_pkg;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast value in order
    logic shl;  // shift the row one place toward cell 0
  } msort_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } msort_state_t;

endpackage

`default_nettype wire

FILE: design/msort_cell.sv
// ----------------------------------------------------------------------------
// msort_cell
// one slot of the sorted row: insert-in-order and shift-out
// ----------------------------------------------------------------------------
`default_nettype none

module msort_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire msort_pkg::msort_ctl_t  ctl,
  input  wire logic [DATA_WIDTH-1:0]  ins_data,
  input  wire logic [DATA_WIDTH-1:0]  left_val,
  input  wire logic                   left_valid,
  input  wire logic                   left_gt,
  input  wire logic [DATA_WIDTH-1:0]  right_val,
  input  wire logic                   right_valid,
  output logic [DATA_WIDTH-1:0]       val,
  output logic                        valid,
  output logic                        gt
);
  import msort_pkg::*;

  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  valid_r, valid_nxt;

  // empty slots count as larger than anything; equal keeps the older one first
  assign gt = !valid_r || ($signed(val_r) > $signed(ins_data));

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.shl) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end else if (ctl.ins && gt) begin
      if (left_gt) begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end else begin
        val_nxt   = ins_data;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

FILE: design/merge_sorter_unit.sv
// ----------------------------------------------------------------------------
// merge_sorter_unit
// collects a set of signed values and returns it in ascending order
// ----------------------------------------------------------------------------
// Values arrive one beat per cycle while in_tready is high and drop straight
// into a row of MAX_ELEMENTS cells that keeps them in ascending order as
// they come in; equal values keep their arrival order. The beat with tlast
// closes the set. The sorted set then leaves from cell 0, one beat per
// cycle while the sink is ready, with tlast on the final value; in_tready
// is low until the final result beat is taken, so loading and draining do
// not overlap. The cell row makes at most one insert or one shift in a cycle.
// Values beyond MAX_ELEMENTS are dropped and out_tuser is high on every
// result of that set.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter_unit #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32,
  localparam int TDATA_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // value_in
  input  wire logic               in_tlast,   // last_in
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // value_out
  output logic                    out_tlast,  // last_out
  output logic                    out_tuser   // overflowed
);
  import msort_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  msort_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             in_beat, out_beat, room;
  msort_ctl_t       ctl;

  logic [DATA_WIDTH-1:0] cell_val   [MAX_ELEMENTS];
  logic                  cell_valid [MAX_ELEMENTS];
  logic                  cell_gt    [MAX_ELEMENTS];

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_DRAIN);
  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_tvalid && out_tready;
  assign room       = (count_r != CNT_FULL);

  assign ctl.ins = in_beat && room;
  assign ctl.shl = out_beat;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_val, r_val;
    logic                  l_valid, l_gt, r_valid;
    if (i == 0) begin : g_head
      assign l_val   = '0;
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
    end else begin : g_body
      assign l_val   = cell_val[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end
    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_val   = cell_val[i+1];
      assign r_valid = cell_valid[i+1];
    end
    msort_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_data   (in_tdata[DATA_WIDTH-1:0]),
      .left_val   (l_val),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .right_val  (r_val),
      .right_valid(r_valid),
      .val        (cell_val[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_beat) begin
          if (room) begin
            count_nxt = count_r + CNT_ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_beat) begin
          count_nxt = count_r - CNT_ONE;
          if (count_r == CNT_ONE) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_tdata = TDATA_W'(cell_val[0]);
  assign out_tlast = (count_r == CNT_ONE);
  assign out_tuser = ovf_r;

endmodule

`default_nettype wire

FILE: design/msort_checker.sv
// ----------------------------------------------------------------------------
// msort_checker
// port-level checks of the merge sorter load and drain sequence
// ----------------------------------------------------------------------------
`default_nettype none

`include "merge_sorter_unit_macros.svh"

module msort_checker #(
  parameter int DATA_WIDTH   = 32,
  localparam int TDATA_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               in_tlast,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic               out_tlast,
  input wire logic               out_tuser
);

  logic               in_last_beat, out_last_beat, out_stall;
  logic [TDATA_W+1:0] out_word;

  assign in_last_beat  = in_tvalid && in_tready && in_tlast;
  assign out_last_beat = out_tvalid && out_tready && out_tlast;
  assign out_stall     = out_tvalid && !out_tready;
  assign out_word      = {out_tuser, out_tlast, out_tdata};

  // no loading while results are pending
  `MSU_ASSERT_NOW(a_no_load_in_drain, out_tvalid, !in_tready, "input ready during drain")
  // closing beat starts the drain
  `MSU_ASSERT_NEXT(a_drain_starts, in_last_beat, out_tvalid, "no result after last beat")
  // final result beat ends the drain
  `MSU_ASSERT_NEXT(a_drain_ends, out_last_beat, !out_tvalid && in_tready, "drain did not end")
  // stalled result holds its value and flags
  `MSU_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind merge_sorter_unit msort_checker #(
  .DATA_WIDTH  (DATA_WIDTH)
) u_msort_checker (.*);

`default_nettype wire
